// ===== rtl/cag_pkg.sv =====
// Package for the cave automaton generation step.
// Holds payload and configuration types, register indexes and default sizes.
// No dependencies.
`default_nettype none

package cag_pkg;

  localparam int ROW_W = 64;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_BIRTH_LIMIT = 2'd1;
  localparam logic [1:0] REG_DEATH_LIMIT = 2'd2;

  localparam logic [6:0] GRID_WIDTH_RST = 7'd64;
  localparam logic [3:0] BIRTH_LIMIT_RST = 4'd4;
  localparam logic [3:0] DEATH_LIMIT_RST = 4'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row_cells;
    logic             final_row;
  } row_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] new_row_cells;
    logic             last_of_grid;
  } row_out_t;

  typedef struct packed {
    logic [6:0] grid_width;
    logic [3:0] birth_limit;
    logic [3:0] death_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/cag_queue.sv =====
// Short queue between the row front and the generation back.
// Flip-flop storage, one read at the head. Uses no package.
`default_nettype none

module cag_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = store[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_push_grows : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ===== rtl/cag_front.sv =====
// Row front: accepts input rows, keeps the two rows before them and queues
// one job per row. Depends on cag_pkg.
`default_nettype none

module cag_front
  import cag_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire row_in_t                   in_data,
  output logic                           in_stall,
  input  wire logic                      q_full,
  output logic                           q_push,
  output logic [3*MAX_WIDTH+2:0]         q_wdata
);

  logic [MAX_WIDTH-1:0] row_above;
  logic [MAX_WIDTH-1:0] row_middle;
  logic                 have_above;
  logic                 have_middle;
  logic [MAX_WIDTH-1:0] row_in;

  assign row_in   = in_data.row_cells[MAX_WIDTH-1:0];
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_wdata  = {row_above, row_middle, row_in, have_above, have_middle,
                     in_data.final_row};

  always_ff @(posedge clk) begin
    if (q_push) begin
      row_above  <= row_middle;
      row_middle <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_above  <= 1'b0;
      have_middle <= 1'b0;
    end else if (q_push) begin
      if (in_data.final_row) begin
        have_above  <= 1'b0;
        have_middle <= 1'b0;
      end else begin
        have_above  <= have_middle;
        have_middle <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cag_back.sv =====
// Generation back: takes queued jobs, evaluates all columns of a new row in
// parallel and registers each result row. Depends on cag_pkg.
`default_nettype none

module cag_back
  import cag_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfg_t                      cfg,
  input  wire logic                      q_not_empty,
  input  wire logic [3*MAX_WIDTH+2:0]    q_rdata,
  output logic                           q_pop,
  output logic                           out_valid,
  output row_out_t                       out_data,
  input  wire logic                      out_stall
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic                 e_fin;
  logic                 e_hm;
  logic                 e_ha;
  logic [MAX_WIDTH-1:0] e_row;
  logic [MAX_WIDTH-1:0] e_mid;
  logic [MAX_WIDTH-1:0] e_above;

  logic                 second;
  logic                 second_next;
  logic                 load;
  logic                 produce;
  logic                 emit;
  logic                 pick_fin;

  logic [MAX_WIDTH-1:0] up;
  logic                 up_ok;
  logic [MAX_WIDTH-1:0] mid;
  logic [MAX_WIDTH-1:0] down;
  logic                 down_ok;

  logic [WW-1:0]        w;
  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH+1:0] ext_up;
  logic [MAX_WIDTH+1:0] ext_mid;
  logic [MAX_WIDTH+1:0] ext_down;
  logic [MAX_WIDTH-1:0] new_row;
  logic [MAX_WIDTH-1:0] out_row;
  logic                 out_last;

  assign e_fin   = q_rdata[0];
  assign e_hm    = q_rdata[1];
  assign e_ha    = q_rdata[2];
  assign e_row   = q_rdata[3 +: MAX_WIDTH];
  assign e_mid   = q_rdata[3 + MAX_WIDTH +: MAX_WIDTH];
  assign e_above = q_rdata[3 + 2*MAX_WIDTH +: MAX_WIDTH];

  assign load     = !out_valid || !out_stall;
  assign produce  = q_not_empty && (e_hm || e_fin);
  assign emit     = produce && load;
  assign pick_fin = second || !e_hm;
  assign q_pop    = q_not_empty &&
                    (!(e_hm || e_fin) || (emit && (second || !(e_hm && e_fin))));

  always_comb begin
    second_next = second;
    if (emit && e_hm && e_fin && !second) begin
      second_next = 1'b1;
    end else if (q_pop) begin
      second_next = 1'b0;
    end
  end

  always_comb begin
    if (pick_fin) begin
      up      = e_mid;
      up_ok   = e_hm;
      mid     = e_row;
      down    = '0;
      down_ok = 1'b0;
    end else begin
      up      = e_above;
      up_ok   = e_ha;
      mid     = e_mid;
      down    = e_row;
      down_ok = 1'b1;
    end
  end

  always_comb begin
    if (cfg.grid_width == 7'd0) begin
      w = WW'(1);
    end else if (cfg.grid_width > 7'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = cfg.grid_width[WW-1:0];
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      mask[c] = (WW'(c) < w);
    end
    ext_up   = {1'b1, (up_ok ? ((up & mask) | ~mask) : '1), 1'b1};
    ext_mid  = {1'b1, ((mid & mask) | ~mask), 1'b1};
    ext_down = {1'b1, (down_ok ? ((down & mask) | ~mask) : '1), 1'b1};
  end

  always_comb begin
    logic [3:0] n;
    logic       cur;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      n = 4'(ext_up[c]) + 4'(ext_up[c+1]) + 4'(ext_up[c+2])
        + 4'(ext_down[c]) + 4'(ext_down[c+1]) + 4'(ext_down[c+2])
        + 4'(ext_mid[c]) + 4'(ext_mid[c+2]);
      cur = mid[c];
      if (!cur && (n > cfg.birth_limit)) begin
        cur = 1'b1;
      end
      if (cur && (n < cfg.death_limit)) begin
        cur = 1'b0;
      end
      new_row[c] = cur && mask[c];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row  <= new_row;
      out_last <= pick_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      second <= second_next;
      if (load) begin
        out_valid <= produce;
      end
    end
  end

  assign out_data.new_row_cells = ROW_W'(out_row);
  assign out_data.last_of_grid  = out_last;

  a_second_has_job : assert property (@(posedge clk) disable iff (rst)
    second |-> q_not_empty && e_hm && e_fin)
    else $error("second result pending without a two-result job");

  a_second_pops : assert property (@(posedge clk) disable iff (rst)
    emit && second |-> q_pop)
    else $error("job kept after its final result");

  a_hold_stalled : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

// ===== rtl/cave_automaton_generation_step.sv =====
// Top level of the cave automaton generation step: configuration registers,
// row front, job queue and generation back. Depends on cag_pkg.
//
// One grid row is taken per cycle while the job queue is not full, and each
// result row is evaluated with all columns in parallel, so the sustained rate
// is one row per cycle while the output is not stalled; the final row of a
// grid of two or more rows gives two result rows, which costs the back one
// extra evaluation for that grid, absorbed by the job queue (QUEUE_DEPTH
// entries). A result is released by the transfer of the row below it or, for
// the final row, by its own transfer: the job is registered in the queue,
// then is evaluated from the queue head into the output register.
`default_nettype none

module cave_automaton_generation_step
  import cag_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire row_in_t           in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output row_out_t               out_data,
  input  wire logic              out_stall,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int ENTRY_W = 3*MAX_WIDTH + 3;

  cfg_t               cfg;
  logic               wr_en;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_not_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width  <= GRID_WIDTH_RST;
      cfg.birth_limit <= BIRTH_LIMIT_RST;
      cfg.death_limit <= DEATH_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GRID_WIDTH:  cfg.grid_width  <= pwdata[6:0];
        REG_BIRTH_LIMIT: cfg.birth_limit <= pwdata[3:0];
        REG_DEATH_LIMIT: cfg.death_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_WIDTH:  prdata = DATA_W'(cfg.grid_width);
      REG_BIRTH_LIMIT: prdata = DATA_W'(cfg.birth_limit);
      REG_DEATH_LIMIT: prdata = DATA_W'(cfg.death_limit);
      default:         prdata = '0;
    endcase
  end

  cag_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_data (in_data),
    .in_stall(in_stall),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  cag_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .not_empty(q_not_empty)
  );

  cag_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_not_empty(q_not_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire
